/* rtl/dsp_pkg.sv */
// Package for the shortest-path core: widths, constants, op codes and state enum.
// No dependencies; used by every module under rtl.
package dsp_pkg;
  localparam int MaxVertices  = 16;
  localparam int VtxBits      = 4;
  localparam int WeightBits   = 16;
  localparam int DistBits     = 24;
  localparam int EdgeAddrBits = 2 * VtxBits;
  localparam logic [DistBits-1:0] DistInf = {DistBits{1'b1}};

  typedef logic [1:0] op_t;
  localparam op_t OpWrite  = 2'd0;
  localparam op_t OpQuery  = 2'd1;
  localparam op_t OpRead   = 2'd2;
  localparam op_t OpUnused = 2'd3;

  typedef enum logic [3:0] {
    StIdle, StInit, StScan, StPick, StRelaxAddr, StRelax,
    StWalk, StEmit, StOneOut
  } state_t;
endpackage

/* rtl/dijkstra_shortest_path_core.sv */
// Shortest-path core top level: control sequencer, search state and output register.
// Depends on dsp_pkg and dsp_edge_ram.
//
// Usage: input words (op, vertices, weight, present) on in_valid/in_ready,
// results on out_valid/out_ready, vertex_count written via cfg_we/cfg_wdata.
// An edge write gives no output word. A distance read gives one word. A
// query runs up to N rounds; each round scans the N vertices one per cycle
// for the closest unfinalised vertex, then relaxes its N outgoing edges, each
// through an address state and a relax state, via the one edge-memory read
// port and the one shared adder/compare. It then walks the predecessor
// chain one vertex a cycle and emits the route source first, one word per
// accepted output. The block takes no new word until all of a query's
// words are taken; a stalled receiver simply holds the output register.
// Reset clears the edge present bits, predecessor-present bits and marks,
// sets distances to infinity and vertex_count to 16; edge weights are not
// cleared.
module dijkstra_shortest_path_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_from_vertex,
  input  logic [3:0]  in_to_vertex,
  input  logic [15:0] in_edge_weight,
  input  logic        in_edge_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_route_vertex,
  output logic [23:0] out_total_distance,
  output logic        out_found,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  localparam int VB = dsp_pkg::VtxBits;
  localparam int DB = dsp_pkg::DistBits;
  localparam int NV = dsp_pkg::MaxVertices;

  dsp_pkg::state_t state_r, state_nxt;
  logic [4:0]    vcount_r;
  logic [NV*NV-1:0] evalid_r;
  logic [DB-1:0] dist_r [NV];
  logic [NV-1:0] fin_r;
  logic [NV-1:0] pvalid_r;          // predecessor present
  logic [VB-1:0] pred_r [NV];
  logic [VB-1:0] stack_r [NV];
  logic [VB-1:0] src_r, dst_r, j_r, pick_r, at_r;
  logic [VB:0]   n_r, round_r, depth_r;
  logic [DB-1:0] least_r;
  logic          picked_r;
  logic [VB-1:0] out_v_r;
  logic [DB-1:0] out_d_r;
  logic          out_f_r, out_l_r, out_valid_r;

  logic [dsp_pkg::WeightBits-1:0] w_rd;
  logic acc, out_take, j_end;
  logic [VB:0] n_act;
  logic [DB:0] sum;

  assign acc      = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;
  assign in_ready = (state_r == dsp_pkg::StIdle) && !out_valid_r;
  assign n_act    = (vcount_r > 5'(NV)) ? (VB+1)'(NV) : vcount_r;
  assign j_end    = ({1'b0, j_r} + 1'b1) >= n_r;

  dsp_edge_ram u_ram (
    .clk(clk), .we(acc && in_op == dsp_pkg::OpWrite),
    .waddr({in_from_vertex, in_to_vertex}), .wdata(in_edge_weight),
    .raddr({pick_r, j_r}), .rdata(w_rd)
  );

  // shared adder/compare for relaxation
  assign sum = {1'b0, dist_r[pick_r]} + {{(DB+1-dsp_pkg::WeightBits){1'b0}}, w_rd};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsp_pkg::StIdle:
        if (acc) begin
          if (in_op == dsp_pkg::OpQuery) begin
            if ({1'b0, in_from_vertex} >= n_act || {1'b0, in_to_vertex} >= n_act)
              state_nxt = dsp_pkg::StOneOut;
            else state_nxt = dsp_pkg::StInit;
          end else if (in_op == dsp_pkg::OpRead) state_nxt = dsp_pkg::StOneOut;
        end
      dsp_pkg::StInit: state_nxt = dsp_pkg::StScan;
      dsp_pkg::StScan: if (j_end) state_nxt = dsp_pkg::StPick;
      dsp_pkg::StPick: begin
        if (!picked_r || pick_r == dst_r) state_nxt = dsp_pkg::StWalk;
        else state_nxt = dsp_pkg::StRelaxAddr;
      end
      dsp_pkg::StRelaxAddr: state_nxt = dsp_pkg::StRelax;
      dsp_pkg::StRelax: begin
        if (j_end) begin
          if (round_r + 1'b1 >= n_r) state_nxt = dsp_pkg::StWalk;
          else state_nxt = dsp_pkg::StScan;
        end else state_nxt = dsp_pkg::StRelaxAddr;
      end
      dsp_pkg::StWalk: begin
        if (dist_r[dst_r] == dsp_pkg::DistInf) state_nxt = dsp_pkg::StOneOut;
        else if (!pvalid_r[at_r] || depth_r + 1'b1 >= (VB+1)'(NV))
          state_nxt = dsp_pkg::StEmit;
      end
      dsp_pkg::StEmit:
        if (out_take && out_l_r) state_nxt = dsp_pkg::StIdle;
      dsp_pkg::StOneOut:
        if (out_take) state_nxt = dsp_pkg::StIdle;
      default: state_nxt = dsp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsp_pkg::StIdle;
      vcount_r    <= 5'd16;
      evalid_r    <= '0;
      fin_r       <= '0;
      pvalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NV; i++) dist_r[i] <= dsp_pkg::DistInf;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vcount_r <= cfg_wdata;
      case (state_r)
        dsp_pkg::StIdle: if (acc) begin
          src_r <= in_from_vertex;
          dst_r <= in_to_vertex;
          n_r   <= n_act;
          if (in_op == dsp_pkg::OpWrite)
            evalid_r[{in_from_vertex, in_to_vertex}] <= in_edge_present;
          if (in_op == dsp_pkg::OpQuery) begin
            out_v_r <= '0; out_d_r <= '0; out_f_r <= 1'b0; out_l_r <= 1'b1;
          end
          if (in_op == dsp_pkg::OpRead) begin
            out_v_r <= in_from_vertex;
            out_l_r <= 1'b1;
            if ({1'b0, in_from_vertex} >= n_act || dist_r[in_from_vertex] == dsp_pkg::DistInf)
            begin
              out_d_r <= '0; out_f_r <= 1'b0;
            end else begin
              out_d_r <= dist_r[in_from_vertex]; out_f_r <= 1'b1;
            end
          end
        end
        dsp_pkg::StInit: begin
          for (int i = 0; i < NV; i++)
            dist_r[i] <= (VB'(i) == src_r) ? '0 : dsp_pkg::DistInf;
          fin_r    <= '0;
          pvalid_r <= '0;
          round_r  <= '0;
          j_r      <= '0;
          least_r  <= dsp_pkg::DistInf;
          picked_r <= 1'b0;
        end
        dsp_pkg::StScan: begin
          if (!fin_r[j_r] && dist_r[j_r] < least_r) begin
            least_r <= dist_r[j_r]; pick_r <= j_r; picked_r <= 1'b1;
          end
          j_r <= j_end ? '0 : j_r + 1'b1;
        end
        dsp_pkg::StPick: begin
          if (picked_r) fin_r[pick_r] <= 1'b1;
          at_r    <= dst_r;
          depth_r <= '0;
        end
        dsp_pkg::StRelax: begin
          if (evalid_r[{pick_r, j_r}] && !fin_r[j_r] && sum < {1'b0, dsp_pkg::DistInf}
              && sum[DB-1:0] < dist_r[j_r]) begin
            dist_r[j_r]   <= sum[DB-1:0];
            pred_r[j_r]   <= pick_r;
            pvalid_r[j_r] <= 1'b1;
          end
          j_r <= j_end ? '0 : j_r + 1'b1;
          if (j_end) begin
            round_r  <= round_r + 1'b1;
            least_r  <= dsp_pkg::DistInf;
            picked_r <= 1'b0;
          end
        end
        dsp_pkg::StWalk: begin
          stack_r[depth_r[VB-1:0]] <= at_r;
          at_r <= pred_r[at_r];
          if (dist_r[dst_r] == dsp_pkg::DistInf) begin
            out_valid_r <= 1'b1;
          end else if (!pvalid_r[at_r] || depth_r + 1'b1 >= (VB+1)'(NV)) begin
            // first route word is the source, at the top of the stack
            out_valid_r <= 1'b1;
            out_v_r <= at_r;
            out_d_r <= dist_r[dst_r];
            out_f_r <= 1'b1;
            out_l_r <= (depth_r == '0);
          end else depth_r <= depth_r + 1'b1;
        end
        dsp_pkg::StEmit: if (out_take) begin
          if (!out_l_r) begin
            depth_r     <= depth_r - 1'b1;
            out_valid_r <= 1'b1;
            out_v_r     <= stack_r[depth_r[VB-1:0] - 1'b1];
            out_l_r     <= (depth_r == (VB+1)'(1));
          end else out_valid_r <= 1'b0;
        end
        dsp_pkg::StOneOut: begin
          if (out_take) out_valid_r <= 1'b0;
          else if (!out_valid_r) out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_route_vertex   = out_v_r;
  assign out_total_distance = out_d_r;
  assign out_found          = out_f_r;
  assign out_last           = out_l_r;

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dsp_pkg::StIdle) |-> !in_ready) else $error("ready while busy");
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_f_r) |-> (out_d_r == '0 && out_l_r)) else $error("bad not-found");
  a_fin_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsp_pkg::StPick && picked_r) |-> (least_r != dsp_pkg::DistInf))
    else $error("picked infinite vertex");
`endif
endmodule

/* rtl/dsp_edge_ram.sv */
// Edge weight memory: 256 x 16, one write port, one registered read port.
// Depends on dsp_pkg.
module dsp_edge_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [dsp_pkg::EdgeAddrBits-1:0] waddr,
  input  logic [dsp_pkg::WeightBits-1:0]   wdata,
  input  logic [dsp_pkg::EdgeAddrBits-1:0] raddr,
  output logic [dsp_pkg::WeightBits-1:0]   rdata
);
  logic [dsp_pkg::WeightBits-1:0] mem [2**dsp_pkg::EdgeAddrBits];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
